// ----- rtl/sukt_pkg.sv -----
// Shared types and codes for the sorted unique-key table.
package sukt_pkg;

    localparam int ID_W     = 32;
    localparam int SCORE_W  = 16;
    localparam int STATUS_W = 3;

    // Operation codes on the request channel
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUMPED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // One stored table entry
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                start;      // latch request, clear scan state
        logic                scan;       // duplicate / insertion point scan
        logic                shift;      // move entries up one slot
        logic                insert;     // write new entry at insertion point
        logic                dump_rd;    // read next entry for a dump
        logic                load_out;   // load the result register
        logic [STATUS_W-1:0] out_status; // status for the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic dup;
        logic scan_done;
        logic shift_done;
        logic out_last;
    } sts_t;

endpackage

// ----- rtl/sukt_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface sukt_req_if
    import sukt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [ID_W-1:0]           key_id;
    logic signed [SCORE_W-1:0] entry_score;

    modport source (output valid, func, key_id, entry_score, input ready);
    modport sink   (input valid, func, key_id, entry_score, output ready);
endinterface

interface sukt_rsp_if
    import sukt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [ID_W-1:0]           out_id;
    logic signed [SCORE_W-1:0] out_score;
    logic                      last;

    modport source (output valid, status, out_id, out_score, last, input ready);
    modport sink   (input valid, status, out_id, out_score, last, output ready);
endinterface

// ----- rtl/sorted_unique_key_table_top.sv -----
// Top level of the sorted unique-key table.
//
//   channel  dir  payload                               handshake
//   req      in   func, key_id, entry_score             valid/ready
//   rsp      out  status, out_id, out_score, last       valid/ready
//
// Insert: accept, scan for a duplicate and the insertion point, shift the
// entries from there up one slot, then write the entry and load the result.
// Duplicate and full results come straight after the scan. A dump reads and
// loads each entry in turn, stalled on rsp; one request is handled at a time.
// Reset (rst_n low, asynchronous) empties the table; no clearing pass.
// A stall on rsp holds the result word and the controller in place.
module sorted_unique_key_table_top
    import sukt_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    sukt_req_if.sink   req,
    sukt_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    sukt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sukt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_key_id      (req.key_id),
        .in_entry_score (req.entry_score),
        .cmd            (cmd),
        .sts            (sts),
        .out_status     (rsp.status),
        .out_id         (rsp.out_id),
        .out_score      (rsp.out_score),
        .out_last       (rsp.last)
    );

endmodule

// ----- rtl/sukt_ctrl.sv -----
// Controller state machine for the sorted unique-key table.
module sukt_ctrl
    import sukt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_func,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_DUMP_RD = 3'd3;
    localparam logic [2:0] S_DUMP_LD = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = ST_INSERTED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = (in_func == FUNC_DUMP) ? S_DUMP_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    priority if (sts.dup)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_DUPLICATE;
                        state_next     = S_OUT;
                    end
                    else if (sts.cnt_full)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_FULL;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    cmd.insert     = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_INSERTED;
                    state_next     = S_OUT;
                end
            end
            S_DUMP_RD:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.dump_rd = 1'b1;
                    state_next  = S_DUMP_LD;
                end
            end
            S_DUMP_LD:
            begin
                cmd.load_out   = 1'b1;
                cmd.out_status = ST_DUMPED;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sukt_dp.sv -----
// Datapath: entry memory, scan/shift counters and result register.
module sukt_dp
    import sukt_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ID_W-1:0]           in_key_id,
    input  logic signed [SCORE_W-1:0] in_entry_score,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    output logic [STATUS_W-1:0]       out_status,
    output logic [ID_W-1:0]           out_id,
    output logic signed [SCORE_W-1:0] out_score,
    output logic                      out_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Entry memory, one write and one registered read port
    entry_t mem [CAPACITY];

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic                      found_reg, found_next;
    logic                      dup_reg, dup_next;
    logic                      rd_vld_reg;
    logic [CNT_W-1:0]          rd_idx_reg;
    entry_t                    rd_data_reg;
    logic [ID_W-1:0]           key_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [ID_W-1:0]           out_id_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic                      out_last_reg;

    logic                      rd_en;
    logic [CNT_W-1:0]          rd_idx;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    entry_t                    wr_data;
    logic [CNT_W-1:0]          shift_dst;
    logic                      is_last;

    assign shift_dst = rd_idx_reg + 1'b1;
    assign is_last   = (shift_dst == cnt_reg);

    // Read issue and counter control
    always_comb
    begin
        rd_en    = 1'b0;
        rd_idx   = idx_reg;
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan && (idx_reg < cnt_reg))
        begin
            rd_en    = 1'b1;
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.shift && (idx_reg > pos_reg))
        begin
            rd_en    = 1'b1;
            rd_idx   = idx_reg - 1'b1;
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.dump_rd)
        begin
            rd_en    = 1'b1;
            idx_next = idx_reg + 1'b1;
        end
    end

    // Duplicate check and insertion point on returned read data
    always_comb
    begin
        dup_next   = dup_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        if (cmd.start)
        begin
            dup_next   = 1'b0;
            found_next = 1'b0;
            pos_next   = cnt_reg;
        end
        else if (cmd.scan && rd_vld_reg)
        begin
            if (rd_data_reg.id == key_reg)
            begin
                dup_next = 1'b1;
            end
            if (!found_reg && (rd_data_reg.score < score_reg))
            begin
                found_next = 1'b1;
                pos_next   = rd_idx_reg;
            end
        end
    end

    // Memory write: shifted entry or the new entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = shift_dst[AW-1:0];
        wr_data = rd_data_reg;
        if (cmd.insert)
        begin
            wr_en        = 1'b1;
            wr_addr      = pos_reg[AW-1:0];
            wr_data.id   = key_reg;
            wr_data.score = score_reg;
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            wr_en = 1'b1;
        end
    end

    assign cnt_next = cmd.insert ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            dup_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            dup_reg    <= dup_next;
            rd_vld_reg <= rd_en;
            rd_idx_reg <= rd_idx;
        end
    end

    // Request word and result register
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg   <= in_key_id;
            score_reg <= in_entry_score;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == ST_DUMPED)
            begin
                out_id_reg    <= rd_data_reg.id;
                out_score_reg <= rd_data_reg.score;
                out_last_reg  <= is_last;
            end
            else
            begin
                out_id_reg    <= '0;
                out_score_reg <= '0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.cnt_full   = (cnt_reg == CNT_W'(CAPACITY));
    assign sts.dup        = dup_reg;
    assign sts.scan_done  = (idx_reg == cnt_reg) && !rd_vld_reg;
    assign sts.shift_done = (idx_reg == pos_reg) && !rd_vld_reg;
    assign sts.out_last   = out_last_reg;

    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_score  = out_score_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- tb/sv/tb_sorted_unique_key_table_top.sv -----
// Self-checking testbench for the sorted unique-key table top level.
`timescale 1ns / 1ps

module tb_sorted_unique_key_table_top;
    import sukt_pkg::*;

    localparam int TABLE_CAP    = 32;
    localparam int IDLE_PCT     = 37;
    localparam int SETTLE_END   = 2 * TABLE_CAP + 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int BURST_ITEMS  = 80;

    // One expected result word
    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   no_gaps;
    int   mismatch_count;

    // Shadow copy of the table, updated on every accepted request
    logic [ID_W-1:0]           table_ids [TABLE_CAP];
    logic signed [SCORE_W-1:0] table_scores [TABLE_CAP];
    int                        table_count;
    table_result_t             pending_results [$];

    sukt_req_if req_ch ();
    sukt_rsp_if rsp_ch ();

    sorted_unique_key_table_top #(
        .CAPACITY (TABLE_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Queue the result words one request produces and update the shadow table
    function automatic void predict_request(input logic op, input logic [ID_W-1:0] id,
                                            input logic signed [SCORE_W-1:0] score);
        table_result_t r;
        bit            dup;
        int            pos;
        dup = 1'b0;
        pos = table_count;
        r.id    = '0;
        r.score = '0;
        r.last  = 1'b1;
        if (op == FUNC_DUMP)
        begin
            if (table_count == 0)
            begin
                r.status = ST_EMPTY;
                pending_results.insert(pending_results.size(), r);
            end
            for (int i = 0; i < table_count; i++)
            begin
                r.status = ST_DUMPED;
                r.id     = table_ids[i];
                r.score  = table_scores[i];
                r.last   = (i == table_count - 1);
                pending_results.insert(pending_results.size(), r);
            end
            return;
        end
        for (int i = 0; i < table_count; i++)
            if (table_ids[i] == id)
                dup = 1'b1;
        if (dup)
            r.status = ST_DUPLICATE;
        else if (table_count >= TABLE_CAP)
            r.status = ST_FULL;
        else
        begin
            // new entry goes before the first strictly lower score
            for (int i = table_count - 1; i >= 0; i--)
                if (table_scores[i] < score)
                    pos = i;
            for (int i = table_count; i > pos; i--)
            begin
                table_ids[i]    = table_ids[i-1];
                table_scores[i] = table_scores[i-1];
            end
            table_ids[pos]    = id;
            table_scores[pos] = score;
            table_count++;
            r.status = ST_INSERTED;
        end
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Monitor both channels: predict on request, compare on result
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n === 1'b1)
        begin
            if (req_ch.valid && req_ch.ready)
                predict_request(req_ch.func, req_ch.key_id, req_ch.entry_score);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: status %0d id %0h score %0d",
                           rsp_ch.status, rsp_ch.out_id, rsp_ch.out_score);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatch_count++;
                    end
                    if (rsp_ch.out_id !== want.id)
                    begin
                        $error("out_id: expected %0h, got %0h", want.id, rsp_ch.out_id);
                        mismatch_count++;
                    end
                    if (rsp_ch.out_score !== want.score)
                    begin
                        $error("out_score: expected %0d, got %0d", want.score,
                               rsp_ch.out_score);
                        mismatch_count++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk)
        rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    // Present one request word and hold it until accepted
    task automatic send_op(input logic op, input logic [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] score);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= op;
        req_ch.key_id      <= id;
        req_ch.entry_score <= score;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_drain(input int settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Random request: mostly inserts, some reusing stored ids, some dumps
    task automatic send_random_op();
        logic                      op;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
        op = ($urandom_range(0, 99) < 12) ? FUNC_DUMP : FUNC_INSERT;
        id = $urandom;
        if (table_count > 0 && $urandom_range(0, 99) < 25)
            id = table_ids[$urandom_range(0, table_count - 1)];
        case ($urandom_range(0, 9))
            0:       score = 16'sh8000;
            1:       score = 16'sh7fff;
            2, 3, 4: score = 16'($urandom_range(0, 4)) - 16'd2;
            default: score = 16'($urandom);
        endcase
        send_op(op, id, score);
    endtask

    // Directed corners: empty dump, score and id extremes, ties, duplicates
    task automatic test_directed();
        send_op(FUNC_DUMP,   32'hffff_ffff, -16'sd1);
        send_op(FUNC_INSERT, 32'h0000_0000, 16'sd0);
        send_op(FUNC_INSERT, 32'hffff_ffff, 16'sh7fff);
        send_op(FUNC_INSERT, 32'h0000_0001, 16'sh8000);
        send_op(FUNC_INSERT, 32'h0000_0000, 16'sd5);
        send_op(FUNC_INSERT, 32'h0000_0002, 16'sd0);
        send_op(FUNC_INSERT, 32'h0000_0003, 16'sd0);
        send_op(FUNC_INSERT, 32'h0000_0004, -16'sd1);
        send_op(FUNC_INSERT, 32'h0000_0005, 16'sd1);
        send_op(FUNC_INSERT, 32'h8000_0000, 16'sh7fff);
        send_op(FUNC_INSERT, 32'hffff_ffff, 16'sh8000);
        send_op(FUNC_DUMP,   32'h5555_aaaa, 16'sh55aa);
        wait_drain(0);
    endtask

    // Sender holds off until the block has answered everything
    task automatic test_pressure();
        send_op(FUNC_INSERT, 32'haaaa_5555, 16'sh2aaa);
        wait_drain(0);
        send_op(FUNC_DUMP, 32'h0, 16'sd0);
        wait_drain(0);
        send_op(FUNC_INSERT, 32'h1234_5678, -16'sh2aab);
        wait_drain(0);
    endtask

    task automatic test_random();
        repeat (RANDOM_ITEMS) send_random_op();
        wait_drain(0);
    endtask

    // Long stretch with both sides always ready
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        repeat (BURST_ITEMS) send_random_op();
        wait_drain(0);
        no_gaps = 1'b0;
    endtask

    // Fill to capacity, then full, duplicate while full, and a full dump
    task automatic test_full_table();
        int missing;
        missing = TABLE_CAP - table_count;
        repeat (missing) send_op(FUNC_INSERT, $urandom, 16'($urandom));
        wait_drain(0);
        send_op(FUNC_INSERT, table_ids[0] ^ 32'h1, 16'sd7);
        send_op(FUNC_INSERT, table_ids[TABLE_CAP-1], 16'sh7fff);
        send_op(FUNC_DUMP, 32'hffff_ffff, 16'shffff);
        wait_drain(SETTLE_END);
    endtask

    initial
    begin
        mismatch_count = 0;
        table_count    = 0;
        no_gaps        = 1'b0;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_INSERT;
        req_ch.key_id      <= '0;
        req_ch.entry_score <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pressure();
        test_random();
        test_back_to_back();
        test_full_table();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
